// ===== rtl/frdo_pkg.sv =====
// shared types and constants of the frame ring with drop-oldest overflow
package frdo_pkg;

  localparam int unsigned SlotCountDefault = 64;
  localparam int unsigned SlotBytesDefault = 2048;
  localparam int unsigned MinLenReset      = 14;

  // fixed field widths
  localparam int unsigned CfgW   = 12;
  localparam int unsigned LimitW = 12;
  localparam int unsigned FlenW  = 12;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned DropW  = 32;

  // request kind
  localparam logic FuncPush = 1'b0;
  localparam logic FuncRead = 1'b1;

  typedef enum logic [2:0] {
    ST_BYTE_OUT  = 3'd0,
    ST_EMPTY     = 3'd1,
    ST_TOO_LONG  = 3'd2,
    ST_STORED    = 3'd3,
    ST_COMMITTED = 3'd4,
    ST_DROPPED   = 3'd5,
    ST_REJECTED  = 3'd6
  } status_e;

  typedef enum logic {
    FSM_IDLE,
    FSM_READ
  } fsm_e;

endpackage

// ===== rtl/frdo_ram.sv =====
// generic simple dual-port ram with registered read data
module frdo_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/frame_ring_drop_oldest_unit.sv =====
// top level of the frame ring: slot byte store, length table and ring control
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+----------------------------------------
//  in      | input     | in_valid_i / in_stall_o | func, data_in, last_in, read_limit
//  out     | output    | out_valid_o/out_stall_i | status, data_out, frame_length,
//          |           |                         | last_out, dropped_count
//  cfg     | input     | cfg_we_i                | min_frame_length (cfg_wdata_i)
//
// a push request writes its byte at the accept edge while the frame fits its slot, and
//   writes the length table only when the frame commits; a read request reads both memories
//   at the accept edge and forms its result from their registered read data in the read state
// an empty-ring read is answered directly without touching the memories
// reset clears the ring pointers, the push state and the drop counter; the memories are
//   left as they are, since no entry is read before it is written
// a stalled result holds the output register; a new request is taken in the same cycle
//   the pending result leaves
module frame_ring_drop_oldest_unit
  import frdo_pkg::*;
#(
  parameter int unsigned SLOT_COUNT = SlotCountDefault,
  parameter int unsigned SLOT_BYTES = SlotBytesDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // configuration
  input  logic              cfg_we_i,
  input  logic [CfgW-1:0]   cfg_wdata_i,
  // request channel
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              func_i,
  input  logic [ByteW-1:0]  data_in_i,
  input  logic              last_in_i,
  input  logic [LimitW-1:0] read_limit_i,
  // result channel
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [2:0]        status_o,
  output logic [ByteW-1:0]  data_out_o,
  output logic [FlenW-1:0]  frame_length_o,
  output logic              last_out_o,
  output logic [DropW-1:0]  dropped_count_o
);

  localparam int unsigned SlotW   = $clog2(SLOT_COUNT);
  localparam int unsigned LenW    = $clog2(SLOT_BYTES + 1);
  localparam int unsigned OffW    = $clog2(SLOT_BYTES);
  localparam int unsigned StoreD  = SLOT_COUNT * SLOT_BYTES;
  localparam int unsigned StoreAW = $clog2(StoreD);
  // compare width wide enough for a frame length and the 12-bit host values
  localparam int unsigned CmpW    = (LenW > CfgW) ? LenW : CfgW;

  // ring control state
  fsm_e              state_q, state_d;
  logic [SlotW-1:0]  head_q, head_d;
  logic [SlotW-1:0]  tail_q, tail_d;
  logic [LenW-1:0]   count_q, count_d;
  logic              ovf_q, ovf_d;
  logic [OffW-1:0]   off_q, off_d;
  logic [DropW-1:0]  drop_q, drop_d;
  logic [CfgW-1:0]   min_q;
  logic [LimitW-1:0] limit_q, limit_d;

  // result register
  logic              out_valid_q, out_valid_d;
  status_e           status_q, status_d;
  logic [ByteW-1:0]  data_q, data_d;
  logic [FlenW-1:0]  flen_q, flen_d;
  logic              last_q, last_d;
  logic [DropW-1:0]  dcnt_q, dcnt_d;
  logic              out_load;
  logic              out_free;

  // memory ports
  logic               store_we;
  logic [StoreAW-1:0] store_waddr;
  logic [StoreAW-1:0] store_raddr;
  logic [ByteW-1:0]   store_rdata;
  logic               len_we;
  logic [LenW-1:0]    len_wdata;
  logic [LenW-1:0]    len_rdata;
  logic               mem_re;

  // push path helpers
  logic              stored;
  logic [LenW-1:0]   cnt_inc;
  logic              ovf_new;
  logic [SlotW-1:0]  head_nxt;
  logic [SlotW-1:0]  tail_nxt;
  logic              rd_last;

  function automatic logic [SlotW-1:0] next_slot(input logic [SlotW-1:0] s);
    logic [SlotW-1:0] r;
    if (s == SlotW'(SLOT_COUNT - 1)) begin
      r = '0;
    end else begin
      r = s + SlotW'(1);
    end
    return r;
  endfunction

  assign head_nxt = next_slot(head_q);
  assign tail_nxt = next_slot(tail_q);

  // byte address is slot * slot size + offset within the slot
  assign store_waddr = StoreAW'(head_q) * StoreAW'(SLOT_BYTES) + StoreAW'(count_q);
  assign store_raddr = StoreAW'(tail_q) * StoreAW'(SLOT_BYTES) + StoreAW'(off_q);

  // a byte is stored only while the frame still fits its slot
  assign stored    = !ovf_q && (count_q < LenW'(SLOT_BYTES));
  assign cnt_inc   = count_q + LenW'(stored);
  assign ovf_new   = ovf_q | ~stored;
  assign len_wdata = cnt_inc;
  assign rd_last   = (LenW'(off_q) + LenW'(1)) >= len_rdata;

  // the result register frees up when empty or when its result leaves this cycle
  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = !((state_q == FSM_IDLE) && out_free);

  always_comb begin
    state_d  = state_q;
    head_d   = head_q;
    tail_d   = tail_q;
    count_d  = count_q;
    ovf_d    = ovf_q;
    off_d    = off_q;
    drop_d   = drop_q;
    limit_d  = limit_q;
    store_we = 1'b0;
    len_we   = 1'b0;
    mem_re   = 1'b0;
    out_load = 1'b0;
    status_d = status_q;
    data_d   = '0;
    flen_d   = '0;
    last_d   = 1'b0;

    case (state_q)
      FSM_IDLE: begin
        if (in_valid_i && out_free) begin
          if (func_i == FuncPush) begin
            out_load = 1'b1;
            store_we = stored;
            if (!last_in_i) begin
              count_d  = cnt_inc;
              ovf_d    = ovf_new;
              status_d = ST_STORED;
            end else if (ovf_new || (CmpW'(cnt_inc) < CmpW'(min_q))) begin
              // overlong or runt frame is forgotten
              count_d  = '0;
              ovf_d    = 1'b0;
              status_d = ST_REJECTED;
            end else begin
              len_we   = 1'b1;
              head_d   = head_nxt;
              count_d  = '0;
              ovf_d    = 1'b0;
              status_d = ST_COMMITTED;
              // ring full: sacrifice the oldest frame, even a partly read one
              if (head_nxt == tail_q) begin
                tail_d   = tail_nxt;
                off_d    = '0;
                drop_d   = drop_q + DropW'(1);
                status_d = ST_DROPPED;
              end
            end
          end else if (tail_q == head_q) begin
            out_load = 1'b1;
            status_d = ST_EMPTY;
          end else begin
            // fetch byte and frame length, finish in the read state
            mem_re  = 1'b1;
            limit_d = read_limit_i;
            state_d = FSM_READ;
          end
        end
      end
      FSM_READ: begin
        if (out_free) begin
          out_load = 1'b1;
          state_d  = FSM_IDLE;
          flen_d   = FlenW'(len_rdata);
          if ((off_q == '0) && (CmpW'(len_rdata) > CmpW'(limit_q))) begin
            // frame does not fit the reader buffer: free it whole
            tail_d   = tail_nxt;
            status_d = ST_TOO_LONG;
          end else begin
            status_d = ST_BYTE_OUT;
            data_d   = store_rdata;
            last_d   = rd_last;
            if (rd_last) begin
              tail_d = tail_nxt;
              off_d  = '0;
            end else begin
              off_d = off_q + OffW'(1);
            end
          end
        end
      end
      default: begin
        state_d = FSM_IDLE;
      end
    endcase

    dcnt_d      = drop_d;
    out_valid_d = out_load || (out_valid_q && out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= FSM_IDLE;
      head_q      <= '0;
      tail_q      <= '0;
      count_q     <= '0;
      ovf_q       <= 1'b0;
      off_q       <= '0;
      drop_q      <= '0;
      min_q       <= CfgW'(MinLenReset);
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      count_q     <= count_d;
      ovf_q       <= ovf_d;
      off_q       <= off_d;
      drop_q      <= drop_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        min_q <= cfg_wdata_i;
      end
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk_i) begin
    limit_q <= limit_d;
    if (out_load) begin
      status_q <= status_d;
      data_q   <= data_d;
      flen_q   <= flen_d;
      last_q   <= last_d;
      dcnt_q   <= dcnt_d;
    end
  end

  // bytes of all slots
  frdo_ram #(
    .Width (ByteW),
    .Depth (StoreD)
  ) u_store_ram (
    .clk_i   (clk_i),
    .we_i    (store_we),
    .waddr_i (store_waddr),
    .wdata_i (data_in_i),
    .re_i    (mem_re),
    .raddr_i (store_raddr),
    .rdata_o (store_rdata)
  );

  // committed frame length per slot
  frdo_ram #(
    .Width (LenW),
    .Depth (SLOT_COUNT)
  ) u_len_ram (
    .clk_i   (clk_i),
    .we_i    (len_we),
    .waddr_i (head_q),
    .wdata_i (len_wdata),
    .re_i    (mem_re),
    .raddr_i (tail_q),
    .rdata_o (len_rdata)
  );

  assign out_valid_o     = out_valid_q;
  assign status_o        = status_q;
  assign data_out_o      = data_q;
  assign frame_length_o  = flen_q;
  assign last_out_o      = last_q;
  assign dropped_count_o = dcnt_q;

endmodule
